>>> sv/ikpl_pkg.sv
// Shared types, widths and the arctangent table for the two-link IK solver.
// No dependencies; imported by every module of the block.
package ikpl_pkg;

  localparam int POS_W     = 16;  // Q4.12 positions
  localparam int LEN_W     = 15;  // Q3.12 link lengths
  localparam int ANG_W     = 16;  // binary angles
  localparam int DIFF_W    = 17;  // target minus base
  localparam int DEN_W     = 31;  // 2ab
  localparam int DIV_W     = 47;  // dividend and remainder
  localparam int Q_W       = 16;  // quotient bits incl. saturation bit
  localparam int V_W       = 17;  // cosine term, Q.15 signed
  localparam int SQ_W      = 32;  // square root radicand and root
  localparam int ATAN_IN_W = 34;  // operand width into the arctangent units
  localparam int CORD_W    = 36;  // CORDIC datapath
  localparam int Z_W       = 32;  // turn accumulator
  localparam int MAX_CORDIC = 24;

  typedef enum logic [1:0] {
    REG_BASE_X   = 2'd0,
    REG_BASE_Y   = 2'd1,
    REG_BASE_LEN = 2'd2,
    REG_SEG_LEN  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [ANG_W-1:0]         wanted;
  } side_t;

  // atan(2^-i) as a fraction of a full turn, 2^32 = one turn
  function automatic logic [Z_W-1:0] atan_entry(input int idx);
    logic [Z_W-1:0] e;
    e = '0;
    unique case (idx)
      0:  e = 32'h20000000;
      1:  e = 32'h12E4051D;
      2:  e = 32'h09FB385B;
      3:  e = 32'h051111D4;
      4:  e = 32'h028B0D43;
      5:  e = 32'h0145D7E1;
      6:  e = 32'h00A2F61E;
      7:  e = 32'h00517C55;
      8:  e = 32'h0028BE53;
      9:  e = 32'h00145F2E;
      10: e = 32'h000A2F98;
      11: e = 32'h000517CC;
      12: e = 32'h00028BE6;
      13: e = 32'h000145F3;
      14: e = 32'h0000A2F9;
      15: e = 32'h0000517C;
      16: e = 32'h000028BE;
      17: e = 32'h0000145F;
      18: e = 32'h00000A2F;
      19: e = 32'h00000517;
      20: e = 32'h0000028B;
      21: e = 32'h00000145;
      22: e = 32'h000000A2;
      23: e = 32'h00000051;
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

>>> sv/two_link_ik_solver_top.sv
// Two-link planar IK solver top: input stages, divider and square root
// chains, three atan2 units and the output register. Depends on ikpl_pkg,
// ikpl_div_cell, ikpl_sqrt_cell, ikpl_atan2.
//
//   port group  direction  handshake             word
//   in_*        into       in_valid / in_ready   target x, y, wanted hand angle
//   out_*       out of     out_valid / out_ready shoulder, elbow, wrist angles
//   cfg_*       into       cfg_valid / cfg_ready register index and data
//
// One word enters per cycle while the output is not stalled; each word passes
// through the 16-cell divider, the 16-cell square root and the CORDIC chain.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// registers. A stalled output freezes every stage; in_ready then stays low.
// cfg_ready is always high.
module two_link_ik_solver_top import ikpl_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_target_x,
  input  logic signed [POS_W-1:0] in_target_y,
  input  logic [ANG_W-1:0]        in_wanted_hand_angle,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ANG_W-1:0]        out_shoulder_angle,
  output logic [ANG_W-1:0]        out_elbow_angle,
  output logic [ANG_W-1:0]        out_wrist_angle,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  cfg_idx_t                cfg_index,
  input  logic [POS_W-1:0]        cfg_data
);

  localparam int NST  = (CORDIC_STAGES > MAX_CORDIC) ? MAX_CORDIC : CORDIC_STAGES;
  localparam int L_A  = NST + 7;
  localparam int NDIV = Q_W;
  localparam int NSQ  = 16;
  localparam int PRE  = 4 + NDIV + 2 + NSQ + 1;

  logic adv;

  // configuration registers
  logic signed [POS_W-1:0] base_x_r, base_y_r;
  logic [LEN_W-1:0]        base_len_r, seg_len_r;
  logic [2*LEN_W-1:0]      aa_r, bb_r;
  logic [2*LEN_W-1:0]      ab;
  logic [DEN_W-1:0]        den_r;
  logic [2*LEN_W+1:0]      reach2_r;
  logic [LEN_W:0]          lsum;

  // front stages
  logic [PRE-1:0]            vld_r;
  side_t                     sd_r [PRE];
  logic signed [DIFF_W-1:0]  dx_in, dy_in, dx0, dy0;
  logic signed [2*DIFF_W-1:0] dxx, dyy;
  logic [2*DIFF_W-1:0]       dxx_r, dyy_r;
  logic [2*DIFF_W-1:0]       c2_sum, c2_r;
  logic signed [2*DIFF_W:0]  num;
  logic [DEN_W-1:0]          mag;
  logic [DIV_W-1:0]          dnum_r;
  logic                      neg_r;
  logic [DEN_W-1:0]          dden_r;

  // divider and square root chains
  logic [DIV_W-1:0]      rem_w [NDIV+1];
  logic [Q_W-1:0]        q_w   [NDIV+1];
  logic [DEN_W-1:0]      den_w [NDIV+1];
  logic                  neg_w [NDIV+1];
  logic [V_W-1:0]        qmag;
  logic signed [V_W-1:0] v_r, v2_r;
  logic signed [2*V_W-1:0] vsq;
  logic [SQ_W-1:0]       rad_r;
  logic [SQ_W-1:0]       n_w [NSQ+1];
  logic [SQ_W-1:0]       r_w [NSQ+1];
  logic signed [V_W-1:0] sv_w [NSQ+1];

  // tip direction
  logic signed [ATAN_IN_W-1:0] tx_r, ty_r, s_r, vt_r;
  logic signed [ATAN_IN_W-1:0] b34, v34, s34, a34;
  logic signed [ATAN_IN_W-1:0] dxa, dya;

  // tail and results
  logic [L_A-1:0]   tv_r;
  logic [ANG_W-1:0] tw_r [L_A];
  logic [ANG_W-1:0] ang_acos, ang_tgt, ang_tip;
  logic [ANG_W-1:0] shoulder, elbow;
  logic             out_valid_r;
  logic [ANG_W-1:0] shoulder_r, elbow_r, wrist_r;

  // the whole pipeline advances unless a finished word is held
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r   <= '0;
      base_y_r   <= '0;
      base_len_r <= LEN_W'(4096);
      seg_len_r  <= LEN_W'(4096);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_X:   base_x_r   <= cfg_data;
        REG_BASE_Y:   base_y_r   <= cfg_data;
        REG_BASE_LEN: base_len_r <= cfg_data[LEN_W-1:0];
        REG_SEG_LEN:  seg_len_r  <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  // products of the link lengths, refreshed every cycle
  assign lsum = {1'b0, base_len_r} + {1'b0, seg_len_r};
  assign ab   = base_len_r * seg_len_r;

  always_ff @(posedge clk) begin
    aa_r     <= base_len_r * base_len_r;
    bb_r     <= seg_len_r * seg_len_r;
    den_r    <= {ab, 1'b0};
    reach2_r <= lsum * lsum;
  end

  // stage 0: offsets from the base, side data shift line
  assign dx_in = {in_target_x[POS_W-1], in_target_x} - {base_x_r[POS_W-1], base_x_r};
  assign dy_in = {in_target_y[POS_W-1], in_target_y} - {base_y_r[POS_W-1], base_y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PRE-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= '{dx: dx_in, dy: dy_in, wanted: in_wanted_hand_angle};
      for (int k = 1; k < PRE; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  // stage 1: squares
  assign dx0 = sd_r[0].dx;
  assign dy0 = sd_r[0].dy;
  assign dxx = dx0 * dx0;
  assign dyy = dy0 * dy0;

  // stage 2: distance squared, pulled in to the reach circle
  assign c2_sum = dxx_r + dyy_r;

  // stage 3: cosine numerator magnitude and rounded dividend;
  // a zero divisor saturates the quotient and keeps the sign positive
  assign num = $signed({5'b0, aa_r}) + $signed({5'b0, bb_r}) - $signed({1'b0, c2_r});
  assign mag = num[2*DIFF_W] ? DEN_W'(-num) : DEN_W'(num);

  always_ff @(posedge clk) begin
    if (adv) begin
      dxx_r  <= dxx[2*DIFF_W-1:0];
      dyy_r  <= dyy[2*DIFF_W-1:0];
      c2_r   <= (c2_sum > 34'(reach2_r)) ? 34'(reach2_r) : c2_sum;
      dnum_r <= DIV_W'({mag, 15'b0}) + DIV_W'(den_r >> 1);
      neg_r  <= num[2*DIFF_W] && (den_r != '0);
      dden_r <= den_r;
    end
  end

  // divider chain, top cell flags saturation
  assign rem_w[0] = dnum_r;
  assign q_w[0]   = '0;
  assign den_w[0] = dden_r;
  assign neg_w[0] = neg_r;

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    ikpl_div_cell #(.K(NDIV - 1 - j)) u_div (
      .clk   (clk),
      .en    (adv),
      .rem_i (rem_w[j]),
      .q_i   (q_w[j]),
      .den_i (den_w[j]),
      .neg_i (neg_w[j]),
      .rem_o (rem_w[j+1]),
      .q_o   (q_w[j+1]),
      .den_o (den_w[j+1]),
      .neg_o (neg_w[j+1])
    );
  end

  assign qmag = q_w[NDIV][Q_W-1] ? V_W'(32768) : {2'b0, q_w[NDIV][Q_W-2:0]};
  assign vsq  = v_r * v_r;

  // signed cosine term, then the sine radicand
  always_ff @(posedge clk) begin
    if (adv) begin
      v_r   <= neg_w[NDIV] ? -$signed(qmag) : $signed(qmag);
      rad_r <= SQ_W'(32'h40000000) - SQ_W'(vsq);
      v2_r  <= v_r;
    end
  end

  // square root chain
  assign n_w[0]  = rad_r;
  assign r_w[0]  = '0;
  assign sv_w[0] = v2_r;

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    ikpl_sqrt_cell #(.K(NSQ - 1 - j)) u_sqrt (
      .clk (clk),
      .en  (adv),
      .n_i (n_w[j]),
      .r_i (r_w[j]),
      .v_i (sv_w[j]),
      .n_o (n_w[j+1]),
      .r_o (r_w[j+1]),
      .v_o (sv_w[j+1])
    );
  end

  // tip of the elbow-only arm: (a*2^15 - b*v, -b*s)
  assign a34 = {4'b0, base_len_r, 15'b0};
  assign b34 = {{(ATAN_IN_W-LEN_W){1'b0}}, seg_len_r};
  assign v34 = {{(ATAN_IN_W-V_W){sv_w[NSQ][V_W-1]}}, sv_w[NSQ]};
  assign s34 = {{(ATAN_IN_W-16){1'b0}}, r_w[NSQ][15:0]};

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_r <= a34 - b34 * v34;
      ty_r <= -(b34 * s34);
      s_r  <= s34;
      vt_r <= v34;
    end
  end

  assign dxa = {{(ATAN_IN_W-DIFF_W){sd_r[PRE-1].dx[DIFF_W-1]}}, sd_r[PRE-1].dx};
  assign dya = {{(ATAN_IN_W-DIFF_W){sd_r[PRE-1].dy[DIFF_W-1]}}, sd_r[PRE-1].dy};

  // three arctangent units run side by side
  ikpl_atan2 #(.NST(NST)) u_acos (
    .clk (clk), .en (adv), .y_i (s_r), .x_i (vt_r), .ang_o (ang_acos)
  );

  ikpl_atan2 #(.NST(NST)) u_tgt (
    .clk (clk), .en (adv), .y_i (dya), .x_i (dxa), .ang_o (ang_tgt)
  );

  ikpl_atan2 #(.NST(NST)) u_tip (
    .clk (clk), .en (adv), .y_i (ty_r), .x_i (tx_r), .ang_o (ang_tip)
  );

  // hold valid and wanted angle level with the arctangent units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= '0;
    end else if (adv) begin
      tv_r <= {tv_r[L_A-2:0], vld_r[PRE-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tw_r[0] <= sd_r[PRE-1].wanted;
      for (int k = 1; k < L_A; k++) begin
        tw_r[k] <= tw_r[k-1];
      end
    end
  end

  // output register: combine the angles
  assign elbow    = ANG_W'(16'h8000) + ang_acos;
  assign shoulder = ang_tgt - ang_tip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tv_r[L_A-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      shoulder_r <= shoulder;
      elbow_r    <= elbow;
      wrist_r    <= tw_r[L_A-1] - shoulder - elbow;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_shoulder_angle = shoulder_r;
  assign out_elbow_angle    = elbow_r;
  assign out_wrist_angle    = wrist_r;

  // a held output word freezes the front valid line
  a_stall_front: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("front valid line moved during a stall");

  // a held output word freezes the tail valid line
  a_stall_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tv_r))
    else $error("tail valid line moved during a stall");

  // a new output word only comes from the end of the tail
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(tv_r[L_A-1]))
    else $error("output word without a source");

  // sine and cosine terms stay within one
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[PRE-1] |-> (s_r <= 34'sd32768) && (vt_r <= 34'sd32768) && (vt_r >= -34'sd32768))
    else $error("sine or cosine term out of range");

endmodule

>>> sv/ikpl_div_cell.sv
// One restoring-division step: tries den << K against the remainder.
// Depends on ikpl_pkg.
module ikpl_div_cell import ikpl_pkg::*; #(
  parameter int K = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] rem_i,
  input  logic [Q_W-1:0]   q_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic             neg_i,
  output logic [DIV_W-1:0] rem_o,
  output logic [Q_W-1:0]   q_o,
  output logic [DEN_W-1:0] den_o,
  output logic             neg_o
);

  logic [DIV_W-1:0] rem_r;
  logic [Q_W-1:0]   q_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic [DIV_W-1:0] dsh;

  assign dsh = DIV_W'(den_i) << K;

  // subtract the shifted divisor where it fits, set the quotient bit
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_i >= dsh) begin
        rem_r <= rem_i - dsh;
        q_r   <= q_i | (Q_W'(1) << K);
      end else begin
        rem_r <= rem_i;
        q_r   <= q_i;
      end
      den_r <= den_i;
      neg_r <= neg_i;
    end
  end

  assign rem_o = rem_r;
  assign q_o   = q_r;
  assign den_o = den_r;
  assign neg_o = neg_r;

endmodule

>>> sv/ikpl_sqrt_cell.sv
// One digit of the bit-pair integer square root, trial bit 4^K.
// Depends on ikpl_pkg.
module ikpl_sqrt_cell import ikpl_pkg::*; #(
  parameter int K = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [SQ_W-1:0]       n_i,
  input  logic [SQ_W-1:0]       r_i,
  input  logic signed [V_W-1:0] v_i,
  output logic [SQ_W-1:0]       n_o,
  output logic [SQ_W-1:0]       r_o,
  output logic signed [V_W-1:0] v_o
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

  logic [SQ_W-1:0]       n_r;
  logic [SQ_W-1:0]       r_r;
  logic signed [V_W-1:0] v_r;
  logic [SQ_W-1:0]       trial;

  assign trial = r_i + BIT;

  // take the digit where the trial fits, carry the cosine term along
  always_ff @(posedge clk) begin
    if (en) begin
      if (n_i >= trial) begin
        n_r <= n_i - trial;
        r_r <= (r_i >> 1) + BIT;
      end else begin
        n_r <= n_i;
        r_r <= r_i >> 1;
      end
      v_r <= v_i;
    end
  end

  assign n_o = n_r;
  assign r_o = r_r;
  assign v_o = v_r;

endmodule

>>> sv/ikpl_cordic_cell.sv
// One CORDIC vectoring micro-rotation by atan(2^-IDX).
// Depends on ikpl_pkg.
module ikpl_cordic_cell import ikpl_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [CORD_W-1:0] x_i,
  input  logic signed [CORD_W-1:0] y_i,
  input  logic [Z_W-1:0]           z_i,
  output logic signed [CORD_W-1:0] x_o,
  output logic signed [CORD_W-1:0] y_o,
  output logic [Z_W-1:0]           z_o
);

  localparam logic [Z_W-1:0] ANG = atan_entry(IDX);

  logic signed [CORD_W-1:0] x_r, y_r;
  logic [Z_W-1:0]           z_r;
  logic signed [CORD_W-1:0] xs, ys;

  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;

  // rotate towards the x axis, accumulate the angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_i[CORD_W-1]) begin
        x_r <= x_i + ys;
        y_r <= y_i - xs;
        z_r <= z_i + ANG;
      end else begin
        x_r <= x_i - ys;
        y_r <= y_i + xs;
        z_r <= z_i - ANG;
      end
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

>>> sv/ikpl_atan2.sv
// Pipelined binary-angle atan2: half-turn fold, five normalising shifts,
// a chain of CORDIC cells and rounding. Depends on ikpl_pkg, ikpl_cordic_cell.
module ikpl_atan2 import ikpl_pkg::*; #(
  parameter int NST = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [ATAN_IN_W-1:0] y_i,
  input  logic signed [ATAN_IN_W-1:0] x_i,
  output logic [ANG_W-1:0]            ang_o
);

  localparam int NNORM = 5;

  logic signed [CORD_W-1:0] xe, ye, xh, yh;
  logic [CORD_W-1:0]        ax, ay;
  logic                     xneg;

  logic signed [CORD_W-1:0] nx_r [NNORM+1];
  logic signed [CORD_W-1:0] ny_r [NNORM+1];
  logic [CORD_W-1:0]        nm_r [NNORM+1];
  logic [Z_W-1:0]           nz_r [NNORM+1];
  logic                     zf_r [NNORM+1];

  logic signed [CORD_W-1:0] cx [NST+1];
  logic signed [CORD_W-1:0] cy [NST+1];
  logic [Z_W-1:0]           cz [NST+1];
  logic                     zd_r [NST];
  logic [ANG_W-1:0]         ang_r;
  logic [Z_W-1:0]           zrnd;

  // fold the left half plane over by a half turn
  assign xe   = {{(CORD_W-ATAN_IN_W){x_i[ATAN_IN_W-1]}}, x_i};
  assign ye   = {{(CORD_W-ATAN_IN_W){y_i[ATAN_IN_W-1]}}, y_i};
  assign xneg = xe[CORD_W-1];
  assign xh   = xneg ? -xe : xe;
  assign yh   = xneg ? -ye : ye;
  assign ax   = xh;
  assign ay   = yh[CORD_W-1] ? CORD_W'(-yh) : CORD_W'(yh);

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r[0] <= xh;
      ny_r[0] <= yh;
      nm_r[0] <= (ax > ay) ? ax : ay;
      nz_r[0] <= xneg ? 32'h80000000 : '0;
      zf_r[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  // normalise: shift by 16, 8, 4, 2, 1 until the larger side reaches 2^30
  for (genvar g = 1; g <= NNORM; g++) begin : g_norm
    localparam int SH = 1 << (NNORM - g);
    localparam logic [CORD_W-1:0] LIM = CORD_W'(1) << (31 - SH);
    always_ff @(posedge clk) begin
      if (en) begin
        if (nm_r[g-1] < LIM) begin
          nx_r[g] <= nx_r[g-1] <<< SH;
          ny_r[g] <= ny_r[g-1] <<< SH;
          nm_r[g] <= nm_r[g-1] << SH;
        end else begin
          nx_r[g] <= nx_r[g-1];
          ny_r[g] <= ny_r[g-1];
          nm_r[g] <= nm_r[g-1];
        end
        nz_r[g] <= nz_r[g-1];
        zf_r[g] <= zf_r[g-1];
      end
    end
  end

  assign cx[0] = nx_r[NNORM];
  assign cy[0] = ny_r[NNORM];
  assign cz[0] = nz_r[NNORM];

  // chain of micro-rotations
  for (genvar i = 0; i < NST; i++) begin : g_cord
    ikpl_cordic_cell #(.IDX(i)) u_cell (
      .clk (clk),
      .en  (en),
      .x_i (cx[i]),
      .y_i (cy[i]),
      .z_i (cz[i]),
      .x_o (cx[i+1]),
      .y_o (cy[i+1]),
      .z_o (cz[i+1])
    );
  end

  // carry the zero-vector flag alongside the rotations
  always_ff @(posedge clk) begin
    if (en) begin
      zd_r[0] <= zf_r[NNORM];
      for (int k = 1; k < NST; k++) begin
        zd_r[k] <= zd_r[k-1];
      end
    end
  end

  // round the accumulator to 16 bits
  assign zrnd = cz[NST] + 32'h00008000;

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= zd_r[NST-1] ? '0 : zrnd[Z_W-1 -: ANG_W];
    end
  end

  assign ang_o = ang_r;

endmodule
